@@ design/cptb_pkg.sv @@
// ----------------------------------------------------------------------------
// cptb_pkg
// Types and widths for the closest point on triangle block.
// ----------------------------------------------------------------------------
package cptb_pkg;

  localparam int CRD_W    = 32;
  localparam int DIF_W    = CRD_W + 1;
  localparam int PRD_W    = 2 * DIF_W;
  localparam int DOT_W    = PRD_W + 2;
  localparam int EDF_W    = DOT_W + 1;
  localparam int LO_W     = DOT_W / 2;
  localparam int HI_W     = DOT_W - LO_W;
  localparam int XPR_W    = 2 * DOT_W;
  localparam int CRS_W    = XPR_W + 1;
  localparam int DIV_W    = CRS_W + 2;
  localparam int WGT_W    = 31;
  localparam int WGT_FRAC = 30;
  localparam int QUO_W    = WGT_FRAC;
  localparam int PRE_STG  = 9;
  localparam int LAT      = PRE_STG + QUO_W + 1;

  localparam logic [WGT_W-1:0] WGT_ONE   = WGT_W'(1) << WGT_FRAC;
  localparam logic [WGT_W-1:0] WGT_THIRD = WGT_W'((64'd1 << WGT_FRAC) / 3);

  typedef struct packed {
    logic signed [CRD_W-1:0] ax;
    logic signed [CRD_W-1:0] ay;
    logic signed [CRD_W-1:0] az;
    logic signed [CRD_W-1:0] bx;
    logic signed [CRD_W-1:0] by_coord;
    logic signed [CRD_W-1:0] bz;
    logic signed [CRD_W-1:0] cx;
    logic signed [CRD_W-1:0] cy;
    logic signed [CRD_W-1:0] cz;
    logic signed [CRD_W-1:0] px;
    logic signed [CRD_W-1:0] py;
    logic signed [CRD_W-1:0] pz;
  } cptb_in_t;

  typedef struct packed {
    logic [WGT_W-1:0] weight_a;
    logic [WGT_W-1:0] weight_b;
    logic [WGT_W-1:0] weight_c;
  } cptb_out_t;

  typedef enum logic [2:0] {
    RG_VTX_A,
    RG_VTX_B,
    RG_EDGE_AB,
    RG_VTX_C,
    RG_EDGE_AC,
    RG_EDGE_BC,
    RG_INNER,
    RG_FLAT
  } region_e;

  // region tests that depend on the dot products only
  typedef struct packed {
    logic in_a;
    logic in_b;
    logic in_c;
    logic d1_ge;
    logic d3_le;
    logic d2_ge;
    logic d6_le;
    logic e43_ge;
    logic e56_ge;
  } flg_t;

endpackage

@@ design/closest_point_on_triangle_bary.sv @@
// ----------------------------------------------------------------------------
// closest_point_on_triangle_bary
// Barycentric weights of the point of triangle ABC closest to P.
//
//   channel | signals                           | carries
//   --------+-----------------------------------+---------------------------
//   in      | in_valid_i, in_ready_o, in_data_i | vertices A, B, C, point P
//   out     | out_valid_o, out_ready_i, out_data_o | weights of A, B, C
//
// One transfer per cycle in each direction while the output is not stalled.
// The 30-step quotient pipeline follows 9 dot/cross stages.
// A stalled output freezes the whole pipeline; nothing is dropped or repeated.
// Reset clears the valid bits only.
// ----------------------------------------------------------------------------
module closest_point_on_triangle_bary (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  cptb_pkg::cptb_in_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output cptb_pkg::cptb_out_t  out_data_o
);

  localparam int CRD_W = cptb_pkg::CRD_W;
  localparam int DIF_W = cptb_pkg::DIF_W;
  localparam int PRD_W = cptb_pkg::PRD_W;
  localparam int DOT_W = cptb_pkg::DOT_W;
  localparam int EDF_W = cptb_pkg::EDF_W;
  localparam int LO_W  = cptb_pkg::LO_W;
  localparam int HI_W  = cptb_pkg::HI_W;
  localparam int XPR_W = cptb_pkg::XPR_W;
  localparam int CRS_W = cptb_pkg::CRS_W;
  localparam int DIV_W = cptb_pkg::DIV_W;
  localparam int WGT_W = cptb_pkg::WGT_W;
  localparam int QUO_W = cptb_pkg::QUO_W;
  localparam int LAT   = cptb_pkg::LAT;

  // operand pairs of the six wide products: d1*d4, d3*d2, d5*d2, d1*d6, d3*d6, d5*d4
  localparam int MUL_L [6] = '{0, 2, 4, 0, 2, 4};
  localparam int MUL_R [6] = '{3, 1, 1, 5, 5, 3};

  logic           en;
  logic [LAT-1:0] vld_q;

  assign en          = !vld_q[LAT-1] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], in_valid_i};
    end
  end

  // stage 1: edge and offset vectors
  logic signed [CRD_W-1:0] vtx [4][3];
  logic signed [DIF_W-1:0] edg_q [2][3];
  logic signed [DIF_W-1:0] ofs_q [3][3];

  assign vtx[0][0] = in_data_i.ax;
  assign vtx[0][1] = in_data_i.ay;
  assign vtx[0][2] = in_data_i.az;
  assign vtx[1][0] = in_data_i.bx;
  assign vtx[1][1] = in_data_i.by_coord;
  assign vtx[1][2] = in_data_i.bz;
  assign vtx[2][0] = in_data_i.cx;
  assign vtx[2][1] = in_data_i.cy;
  assign vtx[2][2] = in_data_i.cz;
  assign vtx[3][0] = in_data_i.px;
  assign vtx[3][1] = in_data_i.py;
  assign vtx[3][2] = in_data_i.pz;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        for (int e = 0; e < 2; e++) begin
          edg_q[e][j] <= DIF_W'(vtx[e+1][j]) - DIF_W'(vtx[0][j]);
        end
        for (int o = 0; o < 3; o++) begin
          ofs_q[o][j] <= DIF_W'(vtx[3][j]) - DIF_W'(vtx[o][j]);
        end
      end
    end
  end

  // stage 2: component products, stage 3: dot products d1..d6
  logic signed [PRD_W-1:0] prd_q [6][3];
  logic signed [DOT_W-1:0] dot_q [6];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 6; k++) begin
        for (int j = 0; j < 3; j++) begin
          prd_q[k][j] <= edg_q[k%2][j] * ofs_q[k/2][j];
        end
        dot_q[k] <= DOT_W'(prd_q[k][0]) + DOT_W'(prd_q[k][1]) + DOT_W'(prd_q[k][2]);
      end
    end
  end

  // stage 4: partial products of the cross terms, dot-only region tests
  logic signed [2*HI_W-1:0]    pp_hh_q [6];
  logic signed [HI_W+LO_W:0]   pp_hl_q [6];
  logic signed [HI_W+LO_W:0]   pp_lh_q [6];
  logic        [2*LO_W-1:0]    pp_ll_q [6];
  logic signed [DOT_W-1:0]     dot4_q [6];
  logic signed [EDF_W-1:0]     e43, e56, e43_4_q, e56_4_q;
  cptb_pkg::flg_t              flg_d, flg4_q;

  assign e43 = EDF_W'(dot_q[3]) - EDF_W'(dot_q[2]);
  assign e56 = EDF_W'(dot_q[4]) - EDF_W'(dot_q[5]);

  always_comb begin
    flg_d.in_a   = (dot_q[0][DOT_W-1] || dot_q[0] == '0) &&
                   (dot_q[1][DOT_W-1] || dot_q[1] == '0);
    flg_d.in_b   = !dot_q[2][DOT_W-1] && (e43[EDF_W-1] || e43 == '0);
    flg_d.in_c   = !dot_q[5][DOT_W-1] && (e56[EDF_W-1] || e56 == '0);
    flg_d.d1_ge  = !dot_q[0][DOT_W-1];
    flg_d.d3_le  = dot_q[2][DOT_W-1] || dot_q[2] == '0;
    flg_d.d2_ge  = !dot_q[1][DOT_W-1];
    flg_d.d6_le  = dot_q[5][DOT_W-1] || dot_q[5] == '0;
    flg_d.e43_ge = !e43[EDF_W-1];
    flg_d.e56_ge = !e56[EDF_W-1];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int m = 0; m < 6; m++) begin
        pp_hh_q[m] <= $signed(dot_q[MUL_L[m]][DOT_W-1:LO_W]) *
                      $signed(dot_q[MUL_R[m]][DOT_W-1:LO_W]);
        pp_hl_q[m] <= $signed(dot_q[MUL_L[m]][DOT_W-1:LO_W]) *
                      $signed({1'b0, dot_q[MUL_R[m]][LO_W-1:0]});
        pp_lh_q[m] <= $signed({1'b0, dot_q[MUL_L[m]][LO_W-1:0]}) *
                      $signed(dot_q[MUL_R[m]][DOT_W-1:LO_W]);
        pp_ll_q[m] <= dot_q[MUL_L[m]][LO_W-1:0] * dot_q[MUL_R[m]][LO_W-1:0];
      end
      dot4_q  <= dot_q;
      e43_4_q <= e43;
      e56_4_q <= e56;
      flg4_q  <= flg_d;
    end
  end

  // stage 5: wide products, stage 6: cross terms va, vb, vc
  logic signed [XPR_W-1:0] prod_q [6];
  logic signed [DOT_W-1:0] dot5_q [6], dot6_q [6];
  logic signed [EDF_W-1:0] e43_5_q, e56_5_q, e43_6_q, e56_6_q;
  cptb_pkg::flg_t          flg5_q, flg6_q;
  logic signed [CRS_W-1:0] vc_q, vb_q, va_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int m = 0; m < 6; m++) begin
        prod_q[m] <= (XPR_W'(pp_hh_q[m]) << (2*LO_W)) + (XPR_W'(pp_hl_q[m]) << LO_W) +
                     (XPR_W'(pp_lh_q[m]) << LO_W) + XPR_W'(pp_ll_q[m]);
      end
      dot5_q  <= dot4_q;
      e43_5_q <= e43_4_q;
      e56_5_q <= e56_4_q;
      flg5_q  <= flg4_q;
      vc_q    <= CRS_W'(prod_q[0]) - CRS_W'(prod_q[1]);
      vb_q    <= CRS_W'(prod_q[2]) - CRS_W'(prod_q[3]);
      va_q    <= CRS_W'(prod_q[4]) - CRS_W'(prod_q[5]);
      dot6_q  <= dot5_q;
      e43_6_q <= e43_5_q;
      e56_6_q <= e56_5_q;
      flg6_q  <= flg5_q;
    end
  end

  // stage 7: region choice and divider operands
  logic signed [DIV_W-1:0] den_in;
  cptb_pkg::region_e       rg_d, rg7_q, rg8_q;
  logic signed [DIV_W-1:0] num_d [2], den_d [2];
  logic signed [DIV_W-1:0] num7_q [2], den7_q [2];
  logic                    vc_le, vb_le, va_le;

  assign den_in = DIV_W'(va_q) + DIV_W'(vb_q) + DIV_W'(vc_q);
  assign vc_le  = vc_q[CRS_W-1] || vc_q == '0;
  assign vb_le  = vb_q[CRS_W-1] || vb_q == '0;
  assign va_le  = va_q[CRS_W-1] || va_q == '0;

  always_comb begin
    priority if (flg6_q.in_a) begin
      rg_d = cptb_pkg::RG_VTX_A;
    end else if (flg6_q.in_b) begin
      rg_d = cptb_pkg::RG_VTX_B;
    end else if (vc_le && flg6_q.d1_ge && flg6_q.d3_le) begin
      rg_d = cptb_pkg::RG_EDGE_AB;
    end else if (flg6_q.in_c) begin
      rg_d = cptb_pkg::RG_VTX_C;
    end else if (vb_le && flg6_q.d2_ge && flg6_q.d6_le) begin
      rg_d = cptb_pkg::RG_EDGE_AC;
    end else if (va_le && flg6_q.e43_ge && flg6_q.e56_ge) begin
      rg_d = cptb_pkg::RG_EDGE_BC;
    end else if (den_in == '0) begin
      rg_d = cptb_pkg::RG_FLAT;
    end else begin
      rg_d = cptb_pkg::RG_INNER;
    end
  end

  always_comb begin
    num_d[0] = '0;
    den_d[0] = '0;
    num_d[1] = '0;
    den_d[1] = '0;
    unique case (rg_d)
      cptb_pkg::RG_EDGE_AB: begin
        num_d[0] = DIV_W'(dot6_q[0]);
        den_d[0] = DIV_W'(dot6_q[0]) - DIV_W'(dot6_q[2]);
      end
      cptb_pkg::RG_EDGE_AC: begin
        num_d[0] = DIV_W'(dot6_q[1]);
        den_d[0] = DIV_W'(dot6_q[1]) - DIV_W'(dot6_q[5]);
      end
      cptb_pkg::RG_EDGE_BC: begin
        num_d[0] = DIV_W'(e43_6_q);
        den_d[0] = DIV_W'(e43_6_q) + DIV_W'(e56_6_q);
      end
      cptb_pkg::RG_INNER: begin
        num_d[0] = DIV_W'(vb_q);
        den_d[0] = den_in;
        num_d[1] = DIV_W'(vc_q);
        den_d[1] = den_in;
      end
      default: begin
      end
    endcase
  end

  // stage 8: magnitudes and sign check, stage 9: saturation check
  logic              kill8_q [2];
  logic [DIV_W-1:0]  nabs8_q [2], dabs8_q [2];

  // quotient pipeline, index 0 is the stage 9 register
  logic [DIV_W-1:0]  dv_rem_q  [2][QUO_W+1];
  logic [DIV_W-1:0]  dv_den_q  [2][QUO_W+1];
  logic [QUO_W-1:0]  dv_quo_q  [2][QUO_W+1];
  logic              dv_sat_q  [2][QUO_W+1];
  logic              dv_kill_q [2][QUO_W+1];
  cptb_pkg::region_e dv_rg_q   [QUO_W+1];
  logic [DIV_W:0]    two_r [2][QUO_W];
  logic [DIV_W:0]    dif   [2][QUO_W];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      for (int k = 0; k < QUO_W; k++) begin
        two_r[l][k] = {dv_rem_q[l][k], 1'b0};
        dif[l][k]   = two_r[l][k] - {1'b0, dv_den_q[l][k]};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rg7_q    <= rg_d;
      num7_q   <= num_d;
      den7_q   <= den_d;
      rg8_q    <= rg7_q;
      dv_rg_q[0] <= rg8_q;
      for (int l = 0; l < 2; l++) begin
        kill8_q[l] <= (den7_q[l] == '0) || (num7_q[l][DIV_W-1] != den7_q[l][DIV_W-1]);
        nabs8_q[l] <= num7_q[l][DIV_W-1] ? DIV_W'(-num7_q[l]) : DIV_W'(num7_q[l]);
        dabs8_q[l] <= den7_q[l][DIV_W-1] ? DIV_W'(-den7_q[l]) : DIV_W'(den7_q[l]);
        dv_rem_q[l][0]  <= nabs8_q[l];
        dv_den_q[l][0]  <= dabs8_q[l];
        dv_quo_q[l][0]  <= '0;
        dv_sat_q[l][0]  <= nabs8_q[l] >= dabs8_q[l];
        dv_kill_q[l][0] <= kill8_q[l];
        for (int k = 0; k < QUO_W; k++) begin
          dv_rem_q[l][k+1]  <= dif[l][k][DIV_W] ? two_r[l][k][DIV_W-1:0]
                                                : dif[l][k][DIV_W-1:0];
          dv_quo_q[l][k+1]  <= {dv_quo_q[l][k][QUO_W-2:0], ~dif[l][k][DIV_W]};
          dv_den_q[l][k+1]  <= dv_den_q[l][k];
          dv_sat_q[l][k+1]  <= dv_sat_q[l][k];
          dv_kill_q[l][k+1] <= dv_kill_q[l][k];
        end
      end
      for (int k = 0; k < QUO_W; k++) begin
        dv_rg_q[k+1] <= dv_rg_q[k];
      end
    end
  end

  // output stage
  logic [WGT_W-1:0]      wt [2];
  logic signed [WGT_W+1:0] u_sum;
  logic [WGT_W-1:0]      u_sat;
  cptb_pkg::cptb_out_t   out_d, out_q;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      if (dv_kill_q[l][QUO_W]) begin
        wt[l] = '0;
      end else if (dv_sat_q[l][QUO_W]) begin
        wt[l] = cptb_pkg::WGT_ONE;
      end else begin
        wt[l] = WGT_W'(dv_quo_q[l][QUO_W]);
      end
    end
    u_sum = (WGT_W+2)'(cptb_pkg::WGT_ONE) - (WGT_W+2)'(wt[0]) - (WGT_W+2)'(wt[1]);
    u_sat = u_sum[WGT_W+1] ? '0 : u_sum[WGT_W-1:0];
  end

  always_comb begin
    out_d = '0;
    unique case (dv_rg_q[QUO_W])
      cptb_pkg::RG_VTX_A: out_d.weight_a = cptb_pkg::WGT_ONE;
      cptb_pkg::RG_VTX_B: out_d.weight_b = cptb_pkg::WGT_ONE;
      cptb_pkg::RG_VTX_C: out_d.weight_c = cptb_pkg::WGT_ONE;
      cptb_pkg::RG_EDGE_AB: begin
        out_d.weight_a = cptb_pkg::WGT_ONE - wt[0];
        out_d.weight_b = wt[0];
      end
      cptb_pkg::RG_EDGE_AC: begin
        out_d.weight_a = cptb_pkg::WGT_ONE - wt[0];
        out_d.weight_c = wt[0];
      end
      cptb_pkg::RG_EDGE_BC: begin
        out_d.weight_b = cptb_pkg::WGT_ONE - wt[0];
        out_d.weight_c = wt[0];
      end
      cptb_pkg::RG_FLAT: begin
        out_d.weight_a = cptb_pkg::WGT_THIRD;
        out_d.weight_b = cptb_pkg::WGT_THIRD;
        out_d.weight_c = cptb_pkg::WGT_THIRD;
      end
      cptb_pkg::RG_INNER: begin
        out_d.weight_a = u_sat;
        out_d.weight_b = wt[0];
        out_d.weight_c = wt[1];
      end
      default: out_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_data_o = out_q;

  a_wgt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_q.weight_a <= cptb_pkg::WGT_ONE) &&
                    (out_q.weight_b <= cptb_pkg::WGT_ONE) &&
                    (out_q.weight_c <= cptb_pkg::WGT_ONE))
    else $error("weight above one");

  a_wgt_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_q.weight_a | out_q.weight_b | out_q.weight_c) != '0)
    else $error("all weights zero");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("pipeline moved during stall");

endmodule

@@ dv/closest_point_on_triangle_bary_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// closest_point_on_triangle_bary_tb
// Streams triangle/point queries through the block under several idle and
// stall patterns and compares every weight triple against an exact
// wide-integer model of the Voronoi region search.
// ----------------------------------------------------------------------------
module closest_point_on_triangle_bary_tb;

  localparam int WIDE     = 192;
  localparam int WD_LIM   = 20000;
  localparam int CRD_W    = cptb_pkg::CRD_W;
  localparam int WGT_W    = cptb_pkg::WGT_W;
  localparam int WGT_FRAC = cptb_pkg::WGT_FRAC;
  localparam int LAT      = cptb_pkg::LAT;

  typedef logic signed [WIDE-1:0] wide_t;

  logic                logic_dummy_unused_guard;
  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  cptb_pkg::cptb_in_t  in_data_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  cptb_pkg::cptb_out_t out_data_o;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned err_cnt = 0;
  int unsigned quiet_cycles = 0;
  cptb_pkg::cptb_out_t weights_due[$];

  assign logic_dummy_unused_guard = 1'b0;

  always #10 clk_i = ~clk_i;

  closest_point_on_triangle_bary u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  function automatic wide_t dot_of(wide_t e0, wide_t e1, wide_t e2,
                                   wide_t f0, wide_t f1, wide_t f2);
    return e0 * f0 + e1 * f1 + e2 * f2;
  endfunction

  function automatic logic [WGT_W-1:0] ratio_weight(wide_t num, wide_t den);
    wide_t q;
    if (den == 0) return '0;
    if ((num < 0) != (den < 0)) return '0;
    if (num < 0) num = -num;
    if (den < 0) den = -den;
    q = (num <<< WGT_FRAC) / den;
    if (q > wide_t'(cptb_pkg::WGT_ONE)) return cptb_pkg::WGT_ONE;
    return WGT_W'(q);
  endfunction

  function automatic cptb_pkg::cptb_out_t closest_weights(cptb_pkg::cptb_in_t q);
    wide_t ab[3], ac[3], ap[3], bp[3], cp[3];
    wide_t d1, d2, d3, d4, d5, d6, va, vb, vc, den, num, u;
    logic [WGT_W-1:0] t, v, w;
    cptb_pkg::cptb_out_t r;
    ab[0] = wide_t'(q.bx) - wide_t'(q.ax);
    ab[1] = wide_t'(q.by_coord) - wide_t'(q.ay);
    ab[2] = wide_t'(q.bz) - wide_t'(q.az);
    ac[0] = wide_t'(q.cx) - wide_t'(q.ax);
    ac[1] = wide_t'(q.cy) - wide_t'(q.ay);
    ac[2] = wide_t'(q.cz) - wide_t'(q.az);
    ap[0] = wide_t'(q.px) - wide_t'(q.ax);
    ap[1] = wide_t'(q.py) - wide_t'(q.ay);
    ap[2] = wide_t'(q.pz) - wide_t'(q.az);
    bp[0] = wide_t'(q.px) - wide_t'(q.bx);
    bp[1] = wide_t'(q.py) - wide_t'(q.by_coord);
    bp[2] = wide_t'(q.pz) - wide_t'(q.bz);
    cp[0] = wide_t'(q.px) - wide_t'(q.cx);
    cp[1] = wide_t'(q.py) - wide_t'(q.cy);
    cp[2] = wide_t'(q.pz) - wide_t'(q.cz);
    d1 = dot_of(ab[0], ab[1], ab[2], ap[0], ap[1], ap[2]);
    d2 = dot_of(ac[0], ac[1], ac[2], ap[0], ap[1], ap[2]);
    if (d1 <= 0 && d2 <= 0) return '{cptb_pkg::WGT_ONE, '0, '0};
    d3 = dot_of(ab[0], ab[1], ab[2], bp[0], bp[1], bp[2]);
    d4 = dot_of(ac[0], ac[1], ac[2], bp[0], bp[1], bp[2]);
    if (d3 >= 0 && d4 - d3 <= 0) return '{'0, cptb_pkg::WGT_ONE, '0};
    vc = d1 * d4 - d3 * d2;
    if (vc <= 0 && d1 >= 0 && d3 <= 0) begin
      t = ratio_weight(d1, d1 - d3);
      return '{cptb_pkg::WGT_ONE - t, t, '0};
    end
    d5 = dot_of(ab[0], ab[1], ab[2], cp[0], cp[1], cp[2]);
    d6 = dot_of(ac[0], ac[1], ac[2], cp[0], cp[1], cp[2]);
    if (d6 >= 0 && d5 - d6 <= 0) return '{'0, '0, cptb_pkg::WGT_ONE};
    vb = d5 * d2 - d1 * d6;
    if (vb <= 0 && d2 >= 0 && d6 <= 0) begin
      t = ratio_weight(d2, d2 - d6);
      return '{cptb_pkg::WGT_ONE - t, '0, t};
    end
    va = d3 * d6 - d5 * d4;
    num = d4 - d3;
    if (va <= 0 && num >= 0 && d5 - d6 >= 0) begin
      t = ratio_weight(num, num + (d5 - d6));
      return '{'0, cptb_pkg::WGT_ONE - t, t};
    end
    den = va + vb + vc;
    if (den == 0) return '{cptb_pkg::WGT_THIRD, cptb_pkg::WGT_THIRD, cptb_pkg::WGT_THIRD};
    v = ratio_weight(vb, den);
    w = ratio_weight(vc, den);
    u = wide_t'(cptb_pkg::WGT_ONE) - wide_t'(v) - wide_t'(w);
    if (u < 0) u = 0;
    if (u > wide_t'(cptb_pkg::WGT_ONE)) u = wide_t'(cptb_pkg::WGT_ONE);
    r.weight_a = WGT_W'(u);
    r.weight_b = v;
    r.weight_c = w;
    return r;
  endfunction

  task automatic send_query(cptb_pkg::cptb_in_t q);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= q;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    weights_due = {weights_due, closest_weights(q)};
  endtask

  always @(posedge clk_i) begin
    out_ready_i <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (weights_due.size() == 0) begin
        $error("unexpected transfer %h", out_data_o);
        err_cnt++;
      end else begin
        cptb_pkg::cptb_out_t e;
        e = weights_due.pop_front();
        if (out_data_o.weight_a !== e.weight_a) begin
          $error("weight_a exp %0d got %0d", e.weight_a, out_data_o.weight_a); err_cnt++;
        end
        if (out_data_o.weight_b !== e.weight_b) begin
          $error("weight_b exp %0d got %0d", e.weight_b, out_data_o.weight_b); err_cnt++;
        end
        if (out_data_o.weight_c !== e.weight_c) begin
          $error("weight_c exp %0d got %0d", e.weight_c, out_data_o.weight_c); err_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WD_LIM) begin
      $display("closest_point_on_triangle_bary verification failed");
      $finish;
    end
  end

  function automatic logic signed [CRD_W-1:0] rnd_coord(int unsigned span);
    case ($urandom_range(5))
      0: return $urandom;
      1: return $urandom_range(1) ? 32'sh7fff_ffff : 32'sh8000_0000;
      default: return $signed($urandom_range(2 * span)) - $signed(span);
    endcase
  endfunction

  function automatic cptb_pkg::cptb_in_t rnd_query();
    cptb_pkg::cptb_in_t q;
    int unsigned span = $urandom_range(1) ? 32'h0004_0000 : 32'h0000_0020;
    q.ax = rnd_coord(span); q.ay = rnd_coord(span); q.az = rnd_coord(span);
    q.bx = rnd_coord(span); q.by_coord = rnd_coord(span); q.bz = rnd_coord(span);
    q.cx = rnd_coord(span); q.cy = rnd_coord(span); q.cz = rnd_coord(span);
    q.px = rnd_coord(span); q.py = rnd_coord(span); q.pz = rnd_coord(span);
    if ($urandom_range(7) == 0) begin
      q.cx = q.bx; q.cy = q.by_coord; q.cz = q.bz;
    end
    return q;
  endfunction

  function automatic cptb_pkg::cptb_in_t tri_query(int ax, int ay, int bx, int by, int cx,
                                                   int cy, int px, int py, int pz);
    return '{ax, ay, 0, bx, by, 0, cx, cy, 0, px, py, pz};
  endfunction

  task automatic test_regions();
    localparam int U = 32'h0001_0000;
    send_query(tri_query(0, 0, 4*U, 0, 0, 4*U, -U, -U, 0));
    send_query(tri_query(0, 0, 4*U, 0, 0, 4*U, 5*U, -U, 0));
    send_query(tri_query(0, 0, 4*U, 0, 0, 4*U, 2*U, -U, U));
    send_query(tri_query(0, 0, 4*U, 0, 0, 4*U, -U, 5*U, 0));
    send_query(tri_query(0, 0, 4*U, 0, 0, 4*U, -U, 2*U, -U));
    send_query(tri_query(0, 0, 4*U, 0, 0, 4*U, 3*U, 3*U, 0));
    send_query(tri_query(0, 0, 4*U, 0, 0, 4*U, U, U, 7*U));
    send_query(tri_query(0, 0, 4*U, 0, 0, 4*U, 0, 0, 0));
    send_query(tri_query(U, U, U, U, U, U, 3*U, 0, 0));
    send_query(tri_query(0, 0, 4*U, 0, 8*U, 0, 2*U, U, 0));
    send_query(tri_query(0, 0, 0, 0, 4*U, 0, 2*U, -U, 0));
    send_query('{12{32'sh7fff_ffff}});
    send_query('{12{32'sh8000_0000}});
    send_query('{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff,
                 32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff,
                 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000});
    send_query('{32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
                 32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000,
                 32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000,
                 32'sh0, 32'sh0, 32'sh0});
  endtask

  task automatic test_random(int unsigned n, int unsigned idle, int unsigned stall);
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    repeat (n) send_query(rnd_query());
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_regions();
    test_random(250, 0, 0);
    test_random(200, 50, 0);
    test_random(200, 0, 50);
    test_random(200, 24, 24);
    in_valid_i <= 1'b0;
    while (weights_due.size() != 0) @(posedge clk_i);
    repeat (LAT + 10) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("closest_point_on_triangle_bary verification clean");
    end else begin
      $display("closest_point_on_triangle_bary verification failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/cptb_pkg.sv
design/closest_point_on_triangle_bary.sv
dv/closest_point_on_triangle_bary_tb.sv
